@@ src/utf8_enc_pkg.sv @@
// package for the utf-8 code point encoder
// holds configuration indexes, lead-byte markers and shared types
// no dependencies
package utf8_enc_pkg;

    // byte slots in one result and width of the count
    localparam int NUM_BYTES = 6;
    localparam int COUNT_W   = 3;
    localparam int CP_W      = 32;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_ORDER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_CONTROL  = 8'd1;

    // lead-byte markers by sequence length
    localparam logic [7:0] LEAD_MARK_2 = 8'hC0;
    localparam logic [7:0] LEAD_MARK_3 = 8'hE0;
    localparam logic [7:0] LEAD_MARK_4 = 8'hF0;
    localparam logic [7:0] LEAD_MARK_5 = 8'hF8;
    localparam logic [7:0] LEAD_MARK_6 = 8'hFC;
    localparam logic [7:0] CONT_MARK   = 8'h80;

    // highest code point rejected by the control filter
    localparam logic [CP_W-1:0] CONTROL_MAX = 32'd8;

    // configuration settings seen by the encoder
    typedef struct packed {
        logic reverse_order;
        logic skip_control;
    } cfg_t;

    // one encoded result
    typedef struct packed {
        logic [NUM_BYTES-1:0][7:0] bytes;
        logic [COUNT_W-1:0]        count;
    } result_t;

endpackage

@@ src/utf8_enc_core.sv @@
// combinational encoder: one code point to up to six utf-8 bytes
// depends on utf8_enc_pkg
module utf8_enc_core (
    input  logic [31:0]           code_point,
    input  utf8_enc_pkg::cfg_t    cfg,
    output utf8_enc_pkg::result_t result
);
    import utf8_enc_pkg::*;

    logic [COUNT_W-1:0] len;
    logic [7:0]         lead;

    // continuation byte carrying six-bit group i, lowest group is 0
    function automatic logic [7:0] cont_sel(input logic [31:0] cp, input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = CONT_MARK | {2'b00, cp[5:0]};
            3'd1:    b = CONT_MARK | {2'b00, cp[11:6]};
            3'd2:    b = CONT_MARK | {2'b00, cp[17:12]};
            3'd3:    b = CONT_MARK | {2'b00, cp[23:18]};
            3'd4:    b = CONT_MARK | {2'b00, cp[29:24]};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // sequence length from the thresholds, with control rejection
    always_comb
    begin
        if (code_point[31])
            len = 3'd0;
        else if (code_point[30:26] != '0)
            len = 3'd6;
        else if (code_point[25:21] != '0)
            len = 3'd5;
        else if (code_point[20:16] != '0)
            len = 3'd4;
        else if (code_point[15:11] != '0)
            len = 3'd3;
        else if (code_point[10:7] != '0)
            len = 3'd2;
        else
            len = 3'd1;
        if (cfg.skip_control && (code_point <= CONTROL_MAX))
            len = 3'd0;
    end

    // lead byte carries the top bits
    always_comb
    begin
        case (len)
            3'd2:    lead = LEAD_MARK_2 | {3'b000, code_point[10:6]};
            3'd3:    lead = LEAD_MARK_3 | {4'b0000, code_point[15:12]};
            3'd4:    lead = LEAD_MARK_4 | {5'b00000, code_point[20:18]};
            3'd5:    lead = LEAD_MARK_5 | {6'b000000, code_point[25:24]};
            3'd6:    lead = LEAD_MARK_6 | {7'b0000000, code_point[30]};
            default: lead = 8'h00;
        endcase
    end

    // place bytes in output order, unused slots zero
    always_comb
    begin
        for (int j = 0; j < NUM_BYTES; j++)
        begin
            result.bytes[j] = 8'h00;
            if (len == 3'd1)
            begin
                if (j == 0)
                    result.bytes[j] = code_point[7:0];
            end
            else if ((len >= 3'd2) && (3'(j) < len))
            begin
                if (cfg.reverse_order)
                    result.bytes[j] = (3'(j) == len - 3'd1) ? lead : cont_sel(code_point, 3'(j));
                else
                    result.bytes[j] = (j == 0) ? lead
                                               : cont_sel(code_point, len - 3'd1 - 3'(j));
            end
        end
        result.count = len;
    end

endmodule

@@ src/utf8_code_point_encoder.sv @@
// top level of the utf-8 code point encoder, six-byte form
// depends on utf8_enc_pkg and utf8_enc_core
//
// Accepts one 32-bit code point per cycle and returns its UTF-8 bytes, one to six, with a
// count; a count of zero marks a rejected code point (0x80000000 and above, or 0 to 8 when
// skip_control is set) and all bytes are then zero. A request accepted into the input
// register passes through the single combinational encode stage into the result register,
// which holds it until the result channel takes it. Each stage takes new data when empty or
// as it hands its own on, so a new code point is taken every cycle while the result side
// keeps up. Configuration writes are always ready, take effect at once and are meant to
// happen while idle; index 0 is reverse_order, index 1 is skip_control, only bit 0 of the
// data is kept and other indexes are ignored.
module utf8_code_point_encoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // code point channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [31:0]                          code_point,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [7:0]                           byte_0,
    output logic [7:0]                           byte_1,
    output logic [7:0]                           byte_2,
    output logic [7:0]                           byte_3,
    output logic [7:0]                           byte_4,
    output logic [7:0]                           byte_5,
    output logic [2:0]                           byte_count,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [utf8_enc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [utf8_enc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import utf8_enc_pkg::*;

    logic       s1_valid_reg;
    logic [31:0] cp_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    cfg_t       cfg_reg;
    logic       s2_ready;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REVERSE_ORDER: cfg_reg.reverse_order <= cfg_data[0];
                CFG_SKIP_CONTROL:  cfg_reg.skip_control  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // stage handshakes
    assign s2_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cp_reg <= code_point;
        if (s1_valid_reg && s2_ready)
            result_reg <= result_next;
    end

    // encode stage
    utf8_enc_core u_core (
        .code_point (cp_reg),
        .cfg        (cfg_reg),
        .result     (result_next)
    );

    // result outputs
    assign out_valid  = out_valid_reg;
    assign byte_0     = result_reg.bytes[0];
    assign byte_1     = result_reg.bytes[1];
    assign byte_2     = result_reg.bytes[2];
    assign byte_3     = result_reg.bytes[3];
    assign byte_4     = result_reg.bytes[4];
    assign byte_5     = result_reg.bytes[5];
    assign byte_count = result_reg.count;

    // a rejected request carries no bytes
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count == 3'd0) |->
            (byte_0 == 8'h00 && byte_1 == 8'h00 && byte_2 == 8'h00 &&
             byte_3 == 8'h00 && byte_4 == 8'h00 && byte_5 == 8'h00))
        else $error("rejected result has non-zero bytes");

    // count never exceeds the slot count and the last slot is clear below six
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count <= 3'd6 && (byte_count == 3'd6 || byte_5 == 8'h00)))
        else $error("byte count out of range or stray last byte");

    // single-byte form is plain ascii
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count == 3'd1) |-> (byte_0[7] == 1'b0 && byte_1 == 8'h00))
        else $error("single-byte result is not ascii");

    // in forward order a multi-byte result opens with a lead byte
    a_lead_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count >= 3'd2 && !cfg_reg.reverse_order) |->
            (byte_0[7:6] == 2'b11 && byte_1[7:6] == 2'b10))
        else $error("forward result does not start with a lead byte");

endmodule

@@ verif/utf8_code_point_encoder_tb.sv @@
// self-checking testbench for the six-byte utf-8 code point encoder
// depends on utf8_enc_pkg and the utf8_code_point_encoder top level
`timescale 1ns / 100ps

module utf8_code_point_encoder_tb;

    import utf8_enc_pkg::*;

    localparam int PIPE_LATENCY  = 2;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 200;
    localparam int TIMEOUT_NS    = 400000;
    localparam int RESET_CYCLES  = 11;

    // first code point of each sequence length, two bytes upwards, then the first rejected one
    localparam logic [CP_W-1:0] LEN_LIMIT [NUM_BYTES] = '{
        32'h0000_0080, 32'h0000_0800, 32'h0001_0000,
        32'h0020_0000, 32'h0400_0000, 32'h8000_0000
    };
    localparam logic [7:0] LEAD_MARK [NUM_BYTES+1] = '{
        8'h00, 8'h00, LEAD_MARK_2, LEAD_MARK_3, LEAD_MARK_4, LEAD_MARK_5, LEAD_MARK_6
    };

    // expected encoding together with the code point that caused it
    typedef struct packed {
        logic [CP_W-1:0] cp;
        result_t         enc;
    } encoding_check_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [CP_W-1:0]        code_point = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [7:0]             byte_0;
    logic [7:0]             byte_1;
    logic [7:0]             byte_2;
    logic [7:0]             byte_3;
    logic [7:0]             byte_4;
    logic [7:0]             byte_5;
    logic [COUNT_W-1:0]     byte_count;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    // predictor copy of the registers
    logic cfg_reverse = 1'b0;
    logic cfg_skip    = 1'b0;

    logic [CP_W-1:0] code_points_to_send [$];
    encoding_check_t expected_encodings [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_request   = 1'b0;
    logic hold_off      = 1'b0;
    int  error_count    = 0;
    int  sent_count     = 0;
    int  checked_count  = 0;
    int  config_writes  = 0;
    int  phase_count    = 0;

    utf8_code_point_encoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_point (code_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_0     (byte_0),
        .byte_1     (byte_1),
        .byte_2     (byte_2),
        .byte_3     (byte_3),
        .byte_4     (byte_4),
        .byte_5     (byte_5),
        .byte_count (byte_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock and reset
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // utf-8 encoding of one code point under the given register settings
    function automatic result_t encode_code_point(input logic [CP_W-1:0] cp,
                                                  input logic rev, input logic skip);
        result_t    r;
        logic [7:0] seq [NUM_BYTES];
        int         len;
        int         i;
        r   = '0;
        len = 0;
        for (i = 0; i < NUM_BYTES; i++)
        begin
            if (cp < LEN_LIMIT[i])
            begin
                len = i + 1;
                break;
            end
        end
        if (skip && cp <= CONTROL_MAX)
            len = 0;
        if (len == 1)
            r.bytes[0] = cp[7:0];
        else if (len >= 2)
        begin
            seq[0] = LEAD_MARK[len] | 8'(cp >> (6 * (len - 1)));
            for (i = 1; i < len; i++)
                seq[i] = CONT_MARK | {2'b00, 6'(cp >> (6 * (len - 1 - i)))};
            for (i = 0; i < len; i++)
                r.bytes[i] = rev ? seq[len - 1 - i] : seq[i];
        end
        r.count = COUNT_W'(len);
        return r;
    endfunction

    // random code point, weighted towards each length class and its edges
    function automatic logic [CP_W-1:0] random_code_point();
        logic [CP_W-1:0] edge_cp;
        edge_cp = LEN_LIMIT[$urandom_range(NUM_BYTES - 1)];
        case ($urandom_range(9))
            0: return $urandom_range(15);
            1: return $urandom_range(32'h7F);
            2: return $urandom_range(32'h7FF, 32'h80);
            3: return $urandom_range(32'hFFFF, 32'h800);
            4: return $urandom_range(32'h1F_FFFF, 32'h1_0000);
            5: return $urandom_range(32'h3FF_FFFF, 32'h20_0000);
            6: return $urandom_range(32'h7FFF_FFFF, 32'h400_0000);
            7: return {1'b1, 31'($urandom)};
            8: return $urandom_range(1) ? edge_cp : edge_cp - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_failure(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // configuration write, model updated once the request is taken
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_REVERSE_ORDER)
            cfg_reverse = data[0];
        else if (index == CFG_SKIP_CONTROL)
            cfg_skip = data[0];
        config_writes++;
    endtask

    // wait until every request has been answered, then let the pipeline settle
    // polled at the falling edge so the driver and monitor have settled
    task automatic drain_outstanding();
        int guard;
        guard = 0;
        while ((code_points_to_send.size() != 0 || in_valid ||
                expected_encodings.size() != 0) && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT)
            report_failure($sformatf("%0d results still outstanding after drain",
                                     expected_encodings.size()));
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic run_random(input int n, input int send_pct, input int recv_pct);
        int i;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        phase_count++;
        for (i = 0; i < n; i++)
            code_points_to_send.push_back(random_code_point());
        drain_outstanding();
    endtask

    // request driver on the code point channel
    always @(posedge clk)
    begin : drive_code_points
        logic busy;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                expected_encodings.push_back(
                    '{cp: code_point,
                      enc: encode_code_point(code_point, cfg_reverse, cfg_skip)});
                sent_count++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (code_points_to_send.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    code_point <= code_points_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk)
    begin : check_results
        result_t         seen;
        encoding_check_t want;
        int              k;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                seen.bytes = {byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};
                seen.count = byte_count;
                if (expected_encodings.size() == 0)
                    report_failure($sformatf("unexpected result, count %0d", byte_count));
                else
                begin
                    want = expected_encodings.pop_front();
                    for (k = 0; k < NUM_BYTES; k++)
                        if (seen.bytes[k] !== want.enc.bytes[k])
                            report_failure($sformatf("cp %h byte_%0d got %h want %h",
                                want.cp, k, seen.bytes[k], want.enc.bytes[k]));
                    if (seen.count !== want.enc.count)
                        report_failure($sformatf("cp %h byte_count got %0d want %0d",
                            want.cp, seen.count, want.enc.count));
                    checked_count++;
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin : receiver_hold_off
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // stimulus sequence
    initial
    begin : run_sequence
        logic [CP_W-1:0] directed_cps [16];
        int              i;
        directed_cps = '{
            32'h0, 32'h8, 32'h9, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF,
            32'h1_0000, 32'h1F_FFFF, 32'h20_0000, 32'h3FF_FFFF, 32'h400_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
        };
        wait (rst_n);
        repeat (2) @(posedge clk);

        // directed: every length edge with reset settings
        phase_count++;
        for (i = 0; i < 16; i++)
            code_points_to_send.push_back(directed_cps[i]);
        drain_outstanding();

        // directed: control rejection and reversal, including the one-byte form
        write_register(CFG_REVERSE_ORDER, 32'h1);
        write_register(CFG_SKIP_CONTROL, 32'h1);
        phase_count++;
        code_points_to_send.push_back(32'h0);
        code_points_to_send.push_back(32'h8);
        code_points_to_send.push_back(32'h9);
        code_points_to_send.push_back(32'h7F);
        code_points_to_send.push_back(32'h7FF);
        code_points_to_send.push_back(32'h7FFF_FFFF);
        code_points_to_send.push_back(32'h8000_0000);
        drain_outstanding();

        // random phases across register settings and idling patterns
        run_random(220, 0, 0);
        write_register(CFG_REVERSE_ORDER, 32'hFFFF_FFFE);
        write_register(CFG_SKIP_CONTROL, 32'h0);
        run_random(220, 62, 0);
        write_register(8'($urandom_range(255, CFG_SKIP_CONTROL + 1)), '1);
        write_register(CFG_REVERSE_ORDER, ($urandom & ~32'h1) | 32'h1);
        run_random(220, 0, 62);
        write_register(CFG_REVERSE_ORDER, 32'h0);
        write_register(CFG_SKIP_CONTROL, 32'h1);
        run_random(220, 6, 6);

        // back-pressure: sender keeps offering while the receiver holds off
        write_register(CFG_REVERSE_ORDER, 32'h1);
        write_register(CFG_SKIP_CONTROL, 32'h0);
        hold_request = 1'b1;
        run_random(250, 0, 0);

        write_register(CFG_REVERSE_ORDER, $urandom & ~32'h1);
        write_register(8'($urandom_range(255, CFG_SKIP_CONTROL + 1)), '0);
        run_random(200, 62, 0);
        write_register(CFG_REVERSE_ORDER, 32'hFFFF_FFFF);
        write_register(CFG_SKIP_CONTROL, 32'hFFFF_FFFF);
        run_random(200, 0, 62);
        write_register(CFG_REVERSE_ORDER, 32'h0);
        run_random(220, 6, 6);

        $display("encoded %0d code points over %0d phases, %0d results checked",
                 sent_count, phase_count, checked_count);
        $display("%0d register writes covered both byte orders with and without rejection",
                 config_writes);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
